FILE: rtl/xdm_pkg.sv
// Shared types and constants for the XOR delta / mask filter block.
// Used by every module under rtl/ except xdm_ram; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package xdm_pkg;

  localparam int WORD_W         = 64;
  localparam int BLOCK_NUM_W    = 32;
  localparam int FILTER_INDEX_W = 9;
  localparam int BLOCK_WORDS_W  = 10;
  localparam int CFG_IDX_W      = 4;
  localparam int CFG_DATA_W     = 10;

  localparam int DEF_MAX_BLOCK_WORDS = 512;
  localparam int DEF_RES_DEPTH       = 4;

  localparam logic [BLOCK_WORDS_W-1:0] BLOCK_WORDS_RESET = 10'd512;

  // input command codes
  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  // result kinds
  localparam logic KIND_DELTA = 1'b0;
  localparam logic KIND_HIT   = 1'b1;

  // mode register codes
  localparam logic MODE_DELTA  = 1'b0;
  localparam logic MODE_FILTER = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCK_WORDS = 4'd0,
    CFG_MODE        = 4'd1
  } cfg_idx_e;

  // data word handed from the front stage to the back stage
  typedef struct packed {
    logic              valid;
    logic              last;
    logic [WORD_W-1:0] word;
  } op_t;

  typedef struct packed {
    logic                   kind;
    logic [WORD_W-1:0]      delta_word;
    logic [BLOCK_NUM_W-1:0] block_number;
    logic                   last_in_block;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } res_push_t;

endpackage

`default_nettype wire

FILE: rtl/xdm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read during a write to the same address returns the old word. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module xdm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/xdm_front.sv
// Front stage: accepts words, tracks the block position, classifies data words
// and filter loads, and drives both line stores. Uses xdm_pkg and xdm_ram.
`timescale 1ns / 1ps
`default_nettype none

module xdm_front
  import xdm_pkg::*;
#(
  parameter int MAX_BLOCK_WORDS = DEF_MAX_BLOCK_WORDS,
  localparam int AW = (MAX_BLOCK_WORDS > 1) ? $clog2(MAX_BLOCK_WORDS) : 1,
  localparam int NW = AW + 1
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      accept_i,
  input  wire logic                      command_i,
  input  wire logic [WORD_W-1:0]         word_i,
  input  wire logic [FILTER_INDEX_W-1:0] filter_index_i,
  input  wire logic [NW-1:0]             n_i,
  input  wire logic                      clear_i,
  output op_t                            op_o,
  output logic      [WORD_W-1:0]         prev_rdata_o,
  output logic      [WORD_W-1:0]         filt_rdata_o
);

  logic [AW-1:0] pos_q, pos_d;
  logic [AW-1:0] p;
  logic          last;
  logic          data_acc;
  logic          load_acc;
  logic [AW-1:0] faddr;
  op_t           op_q, op_d;

  assign data_acc = accept_i && (command_i == CMD_DATA);
  assign load_acc = accept_i && (command_i == CMD_LOAD)
                    && (32'(filter_index_i) < MAX_BLOCK_WORDS);
  assign faddr    = AW'(filter_index_i);

  always_comb begin
    p    = ({1'b0, pos_q} >= n_i) ? '0 : pos_q;
    last = (({1'b0, p} + NW'(1)) == n_i);
  end

  always_comb begin
    pos_d = pos_q;
    if (clear_i) begin
      pos_d = '0;
    end else if (data_acc) begin
      pos_d = last ? '0 : p + AW'(1);
    end
  end

  always_comb begin
    op_d.valid = data_acc;
    op_d.last  = last;
    op_d.word  = word_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      op_q     <= '0;
    end else begin
      pos_q    <= pos_d;
      op_q     <= op_d;
    end
  end

  assign op_o = op_q;

  // previous block: read the old word and overwrite it in the same cycle
  xdm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_BLOCK_WORDS)
  ) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (data_acc),
    .waddr_i (p),
    .wdata_i (word_i),
    .re_i    (data_acc),
    .raddr_i (p),
    .rdata_o (prev_rdata_o)
  );

  xdm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_BLOCK_WORDS)
  ) u_filt_ram (
    .clk_i   (clk_i),
    .we_i    (load_acc),
    .waddr_i (faddr),
    .wdata_i (word_i),
    .re_i    (data_acc),
    .raddr_i (p),
    .rdata_o (filt_rdata_o)
  );

  a_pos_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, pos_q} < n_i)
    else $error("block position reached the block size");

  a_data_reaches_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    data_acc |=> op_q.valid)
    else $error("accepted data word did not reach the back stage");

endmodule

`default_nettype wire

FILE: rtl/xdm_back.sv
// Back stage: combines a data word with the store read data, keeps the block
// state (previous-block flag, hit flag, block count) and builds results. Uses xdm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xdm_back
  import xdm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire op_t               op_i,
  input  wire logic [WORD_W-1:0] prev_rdata_i,
  input  wire logic [WORD_W-1:0] filt_rdata_i,
  input  wire logic              mode_i,
  input  wire logic              clear_i,
  output res_push_t              push_o
);

  logic                   have_prev_q, have_prev_d;
  logic                   hit_q, hit_d;
  logic [BLOCK_NUM_W-1:0] count_q, count_d;
  logic                   hit_now;

  assign hit_now = hit_q || ((op_i.word & filt_rdata_i) != '0);

  always_comb begin
    push_o.valid              = 1'b0;
    push_o.res.kind           = KIND_DELTA;
    push_o.res.delta_word     = op_i.word ^ prev_rdata_i;
    push_o.res.block_number   = '0;
    push_o.res.last_in_block  = op_i.last;
    if (mode_i == MODE_DELTA) begin
      push_o.valid = op_i.valid && have_prev_q;
    end else begin
      push_o.valid              = op_i.valid && op_i.last && hit_now;
      push_o.res.kind           = KIND_HIT;
      push_o.res.delta_word     = '0;
      push_o.res.block_number   = count_q;
      push_o.res.last_in_block  = 1'b1;
    end
  end

  always_comb begin
    have_prev_d = have_prev_q;
    hit_d       = hit_q;
    count_d     = count_q;
    if (clear_i) begin
      have_prev_d = 1'b0;
      hit_d       = 1'b0;
    end else if (op_i.valid) begin
      if (op_i.last) begin
        have_prev_d = 1'b1;
        hit_d       = 1'b0;
        count_d     = count_q + BLOCK_NUM_W'(1);
      end else if (mode_i == MODE_FILTER) begin
        hit_d = hit_now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
      hit_q       <= 1'b0;
      count_q     <= '0;
    end else begin
      have_prev_q <= have_prev_d;
      hit_q       <= hit_d;
      count_q     <= count_d;
    end
  end

  a_no_delta_first_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.valid && push_o.res.kind == KIND_DELTA) |-> have_prev_q)
    else $error("delta result before a full previous block");

  a_count_steps_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i.valid && op_i.last && !clear_i) |=> (count_q == $past(count_q) + 32'd1))
    else $error("block count did not advance at block end");

endmodule

`default_nettype wire

FILE: rtl/xdm_fifo.sv
// Result queue between the back stage and the output ports.
// Small register array with wrap-around pointers. Uses xdm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xdm_fifo
  import xdm_pkg::*;
#(
  parameter int DEPTH = DEF_RES_DEPTH,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire res_t          data_i,
  input  wire logic          pop_i,
  output logic               empty_o,
  output res_t               data_o,
  output logic      [CW-1:0] count_o
);

  res_t          mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          do_pop;

  assign empty_o = (count_q == '0);
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      count_q <= count_q + CW'(push_i) - CW'(do_pop);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/block_xor_delta_and_mask_filter_core.sv
// Top level of the XOR delta / mask filter block: config registers, credit
// check and wiring of front stage, back stage and result queue. Uses xdm_pkg.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------------
//  input    | in        | push_i / full_o    | command_i, word_i, filter_index_i
//  result   | out       | empty_o / pop_i    | kind_o, delta_word_o, block_number_o,
//           |           |                    | last_in_block_o
//  config   | in        | cfg_valid_i/ready  | cfg_index_i, cfg_data_i
//
// One word is accepted per cycle while full_o is low. A data word reads the
// line stores as it is registered into the back stage; the back stage builds its
// result, if any, which is written into the queue and then shows on the result
// ports, where it can be popped. full_o rises when the queue count plus the word
// in the back stage reaches RES_DEPTH; a stalled consumer holds the front once
// RES_DEPTH - 1 results wait with a word in the back stage. No clearing pass
// after reset: the line stores are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module block_xor_delta_and_mask_filter_core
  import xdm_pkg::*;
#(
  parameter int MAX_BLOCK_WORDS = DEF_MAX_BLOCK_WORDS,
  parameter int RES_DEPTH       = DEF_RES_DEPTH
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      push_i,
  output logic                           full_o,
  input  wire logic                      command_i,
  input  wire logic [WORD_W-1:0]         word_i,
  input  wire logic [FILTER_INDEX_W-1:0] filter_index_i,
  output logic                           empty_o,
  input  wire logic                      pop_i,
  output logic                           kind_o,
  output logic      [WORD_W-1:0]         delta_word_o,
  output logic      [BLOCK_NUM_W-1:0]    block_number_o,
  output logic                           last_in_block_o,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int AW = (MAX_BLOCK_WORDS > 1) ? $clog2(MAX_BLOCK_WORDS) : 1;
  localparam int NW = AW + 1;
  localparam int CW = $clog2(RES_DEPTH + 1);

  logic [BLOCK_WORDS_W-1:0] block_words_q;
  logic                     mode_q;
  logic                     cfg_we;
  logic                     clear;
  logic [NW-1:0]            n;
  logic                     accept;
  op_t                      op;
  logic [WORD_W-1:0]        prev_rdata;
  logic [WORD_W-1:0]        filt_rdata;
  res_push_t                res_push;
  res_t                     res_out;
  logic [CW-1:0]            fifo_count;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign clear       = cfg_we && (cfg_index_i == CFG_BLOCK_WORDS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_words_q <= BLOCK_WORDS_RESET;
      mode_q        <= MODE_DELTA;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        CFG_BLOCK_WORDS: block_words_q <= cfg_data_i[BLOCK_WORDS_W-1:0];
        CFG_MODE:        mode_q        <= cfg_data_i[0];
        default:         ;  // drop writes to unknown registers
      endcase
    end
  end

  // clamp the block size to 1 .. MAX_BLOCK_WORDS
  always_comb begin
    if (block_words_q == '0) begin
      n = NW'(1);
    end else if (32'(block_words_q) > MAX_BLOCK_WORDS) begin
      n = NW'(MAX_BLOCK_WORDS);
    end else begin
      n = NW'(block_words_q);
    end
  end

  // reserve a queue slot for the word in the back stage
  assign full_o = ((32'(fifo_count) + 32'(op.valid)) >= RES_DEPTH);
  assign accept = push_i && !full_o;

  xdm_front #(
    .MAX_BLOCK_WORDS (MAX_BLOCK_WORDS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .command_i      (command_i),
    .word_i         (word_i),
    .filter_index_i (filter_index_i),
    .n_i            (n),
    .clear_i        (clear),
    .op_o           (op),
    .prev_rdata_o   (prev_rdata),
    .filt_rdata_o   (filt_rdata)
  );

  xdm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (op),
    .prev_rdata_i (prev_rdata),
    .filt_rdata_i (filt_rdata),
    .mode_i       (mode_q),
    .clear_i      (clear),
    .push_o       (res_push)
  );

  xdm_fifo #(
    .DEPTH (RES_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push.valid),
    .data_i  (res_push.res),
    .pop_i   (pop_i),
    .empty_o (empty_o),
    .data_o  (res_out),
    .count_o (fifo_count)
  );

  assign kind_o          = res_out.kind;
  assign delta_word_o    = res_out.delta_word;
  assign block_number_o  = res_out.block_number;
  assign last_in_block_o = res_out.last_in_block;

  a_no_queue_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push.valid |-> (32'(fifo_count) < RES_DEPTH))
    else $error("result pushed into a full queue");

endmodule

`default_nettype wire
